/* rtl/core/sbr_pkg.sv */
`timescale 1ns / 1ps
package sbr_pkg;

  localparam int unsigned MaxChannels = 4096;
  localparam int unsigned CntW        = 13;
  localparam int unsigned DivSteps    = 78;

  // register indexes
  localparam logic [1:0] CFG_RED  = 2'd0;
  localparam logic [1:0] CFG_BASE = 2'd1;
  localparam logic [1:0] CFG_LOW  = 2'd2;
  localparam logic [1:0] CFG_HIGH = 2'd3;

  // reduction and baseline codes
  localparam logic       RED_SUM  = 1'b0;
  localparam logic       RED_TRAP = 1'b1;
  localparam logic [1:0] BL_MIN   = 2'd1;
  localparam logic [1:0] BL_LIN   = 2'd2;

  localparam logic [63:0] ValMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ValMin = 64'h8000_0000_0000_0000;

  // band snapshot handed from front to back
  typedef struct packed {
    logic               red;
    logic [1:0]         bl;
    logic [27:0]        isum;
    logic [63:0]        trap;
    logic               clip;
    logic signed [45:0] offs;
    logic [15:0]        bmin;
    logic [CntW-1:0]    cnt;
    logic [15:0]        ei;
    logic [31:0]        ep;
    logic [15:0]        iv;
    logic [31:0]        pv;
  } snap_t;

  // clamp to the signed 64-bit range, top bit flags a clamp
  function automatic logic [64:0] sat64(input logic signed [66:0] t);
    logic [64:0] r;
    if (t > $signed({3'b000, ValMax})) r = {1'b1, ValMax};
    else if (t < $signed({3'b111, ValMin})) r = {1'b1, ValMin};
    else r = {1'b0, t[63:0]};
    return r;
  endfunction

endpackage

/* rtl/core/sbr_front.sv */
`timescale 1ns / 1ps
module sbr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [11:0]     ch_i,
  input  logic [15:0]     iv_i,
  input  logic [31:0]     pv_i,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [1:0]      cfg_index_i,
  input  logic [11:0]     cfg_data_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output sbr_pkg::snap_t  q_data_o
);
  import sbr_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_ADD, F_PUSH} fstate_e;

  fstate_e            state_q;
  logic               red_q;
  logic [1:0]         bl_q;
  logic [11:0]        rlo_q, rhi_q;
  logic [11:0]        ch_q;
  logic [15:0]        iv_q;
  logic [31:0]        pv_q;
  logic               emit_q;
  logic [48:0]        prod_q;
  logic               pneg_q;
  logic [27:0]        isum_q;
  logic [63:0]        trap_q;
  logic               clip_q;
  logic signed [45:0] offs_q;
  logic [15:0]        bmin_q, ei_q, pi_q;
  logic [31:0]        ep_q, pp_q;
  logic [CntW-1:0]    cnt_q;

  // classify the latched word and form its deltas, product and trapezoid sum
  logic [11:0] lo, hi;
  logic        in_band, is_lo, is_hi, room;
  logic [32:0] dpp, dep;
  logic [31:0] dmag;
  logic [48:0] prod;
  logic signed [66:0] tsum;
  logic [64:0] tsat;

  always_comb begin
    lo      = (rlo_q < rhi_q) ? rlo_q : rhi_q;
    hi      = (rlo_q < rhi_q) ? rhi_q : rlo_q;
    in_band = !(ch_q < lo || ch_q > hi);
    is_lo   = ch_q == lo;
    is_hi   = ch_q == hi;
    room    = is_hi ? (cnt_q < CntW'(MaxChannels)) : (cnt_q < CntW'(MaxChannels - 1));
    dpp     = {1'b0, pv_q} - {1'b0, pp_q};
    dmag    = dpp[32] ? 32'(-dpp) : dpp[31:0];
    prod    = 49'(dmag) * 49'({1'b0, pi_q} + {1'b0, iv_q});
    dep     = {1'b0, pv_q} - {1'b0, ep_q};
    tsum    = pneg_q ? $signed({{3{trap_q[63]}}, trap_q}) - $signed({18'd0, prod_q})
                     : $signed({{3{trap_q[63]}}, trap_q}) + $signed({18'd0, prod_q});
    tsat    = sat64(tsum);
  end

  assign full_o      = state_q != F_IDLE;
  assign cfg_ready_o = 1'b1;
  assign q_push_o    = (state_q == F_PUSH) && !q_full_i;

  always_comb begin
    q_data_o = '{red: red_q, bl: bl_q, isum: isum_q, trap: trap_q, clip: clip_q,
                 offs: offs_q, bmin: bmin_q, cnt: cnt_q, ei: ei_q, ep: ep_q,
                 iv: iv_q, pv: pv_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      red_q   <= RED_SUM;
      bl_q    <= '0;
      rlo_q   <= '0;
      rhi_q   <= '0;
      emit_q  <= 1'b0;
      isum_q  <= '0;
      trap_q  <= '0;
      clip_q  <= 1'b0;
      offs_q  <= '0;
      bmin_q  <= '1;
      ei_q    <= '0;
      ep_q    <= '0;
      pi_q    <= '0;
      pp_q    <= '0;
      cnt_q   <= '0;
    end else begin
      // register writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_RED:  red_q <= cfg_data_i[0];
          CFG_BASE: bl_q  <= cfg_data_i[1:0];
          CFG_LOW:  rlo_q <= cfg_data_i;
          CFG_HIGH: rhi_q <= cfg_data_i;
          default:  ;
        endcase
      end
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            ch_q    <= ch_i;
            iv_q    <= iv_i;
            pv_q    <= pv_i;
            state_q <= F_CALC;
          end
        end
        F_CALC: begin
          emit_q <= is_hi;
          if (!in_band) begin
            state_q <= F_IDLE;
          end else if (is_lo) begin
            isum_q  <= 28'(iv_q);
            trap_q  <= '0;
            clip_q  <= 1'b0;
            offs_q  <= '0;
            bmin_q  <= iv_q;
            ei_q    <= iv_q;
            ep_q    <= pv_q;
            pi_q    <= iv_q;
            pp_q    <= pv_q;
            cnt_q   <= CntW'(1);
            state_q <= is_hi ? F_PUSH : F_IDLE;
          end else if (room) begin
            isum_q  <= isum_q + 28'(iv_q);
            prod_q  <= prod;
            pneg_q  <= dpp[32];
            offs_q  <= offs_q + $signed({{13{dep[32]}}, dep});
            if (iv_q < bmin_q) bmin_q <= iv_q;
            pi_q    <= iv_q;
            pp_q    <= pv_q;
            cnt_q   <= cnt_q + CntW'(1);
            state_q <= F_ADD;
          end else begin
            state_q <= is_hi ? F_PUSH : F_IDLE;
          end
        end
        F_ADD: begin
          trap_q  <= tsat[63:0];
          if (tsat[64]) clip_q <= 1'b1;
          state_q <= emit_q ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (!q_full_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/sbr_queue.sv */
`timescale 1ns / 1ps
module sbr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbr_pkg::snap_t  data_i,
  output logic            full_o,
  input  logic            pop_i,
  output sbr_pkg::snap_t  data_o,
  output logic            empty_o
);
  import sbr_pkg::*;

  snap_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue pointers skewed");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");

endmodule

/* rtl/core/sbr_back.sv */
`timescale 1ns / 1ps
module sbr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  sbr_pkg::snap_t  q_data_i,
  output logic            q_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output logic [63:0]     band_value_o,
  output logic            zero_span_o,
  output logic            saturated_o
);
  import sbr_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_M1, B_M2, B_DIV, B_FIN} bstate_e;

  bstate_e            state_q;
  snap_t              s_q;
  logic [31:0]        smag_q;
  logic               sneg_q, cneg_q;
  logic [48:0]        m1_q;
  logic [15:0]        dmag_q;
  logic [45:0]        omag_q;
  logic signed [46:0] acc_q;
  logic [77:0]        div_q;
  logic [32:0]        rem_q;
  logic [63:0]        quo_q;
  logic               huge_q;
  logic [6:0]         j_q;
  logic               ov_q;
  logic [63:0]        val_q;
  logic               zs_q, sat_q;

  // span, operand magnitudes, the shared multiplier select and the divider step
  logic [32:0] dsp, div_i;
  logic [16:0] mb;
  logic [31:0] ma;
  logic [30:0] sdiff;
  logic [33:0] rem_sh;
  logic        qbit;

  always_comb begin
    dsp   = {1'b0, s_q.pv} - {1'b0, s_q.ep};
    div_i = {1'b0, s_q.iv} - {1'b0, s_q.ei};
    if (s_q.red == RED_TRAP) begin
      ma = dsp[32] ? 32'(-dsp) : dsp[31:0];
      mb = (s_q.bl == BL_MIN) ? {s_q.bmin, 1'b0} : ({1'b0, s_q.iv} + {1'b0, s_q.ei});
    end else begin
      ma = (s_q.bl == BL_MIN) ? 32'(s_q.bmin) : (s_q.bl == BL_LIN) ? 32'(s_q.ei) : 32'd0;
      mb = 17'(s_q.cnt);
    end
    sdiff  = $signed({3'b000, s_q.isum}) - $signed({2'b00, m1_q[28:0]});
    rem_sh = {rem_q, div_q[77]};
    qbit   = rem_sh >= {2'b00, smag_q};
  end

  // final combine
  logic signed [66:0] tsum, ttrap;
  logic [64:0]        rs, rt;
  logic               tclip, tneg;
  logic [64:0]        tmag;
  logic [63:0]        thalf;
  logic [63:0]        fval;
  logic               fzs, fsat;

  always_comb begin
    tsum  = cneg_q ? $signed({{20{acc_q[46]}}, acc_q}) + $signed({3'b000, quo_q})
                   : $signed({{20{acc_q[46]}}, acc_q}) - $signed({3'b000, quo_q});
    rs    = sat64(tsum);
    if (s_q.bl == BL_MIN || s_q.bl == BL_LIN)
      ttrap = sneg_q ? $signed({{3{s_q.trap[63]}}, s_q.trap}) + $signed({18'd0, m1_q})
                     : $signed({{3{s_q.trap[63]}}, s_q.trap}) - $signed({18'd0, m1_q});
    else
      ttrap = $signed({{3{s_q.trap[63]}}, s_q.trap});
    rt    = sat64(ttrap);
    tclip = s_q.clip || rt[64];
    tneg  = rt[63];
    tmag  = tneg ? 65'(65'd0 - {1'b1, rt[63:0]}) : {1'b0, rt[63:0]};
    thalf = tmag[64:1];
    fzs   = 1'b0;
    fsat  = 1'b0;
    if (s_q.red == RED_TRAP) begin
      if (tclip) begin
        fsat = 1'b1;
        fval = tneg ? ValMin : ValMax;
      end else begin
        fval = tneg ? 64'(-thalf) : thalf;
      end
    end else if (s_q.bl != BL_LIN) begin
      fval = 64'($signed(acc_q));
    end else if (smag_q == '0) begin
      fzs  = 1'b1;
      fval = '0;
    end else if (huge_q) begin
      fsat = 1'b1;
      fval = cneg_q ? ValMax : ValMin;
    end else begin
      fsat = rs[64];
      fval = rs[63:0];
    end
  end

  assign q_pop_o      = (state_q == B_IDLE) && !q_empty_i;
  assign empty_o      = !ov_q;
  assign band_value_o = val_q;
  assign zero_span_o  = zs_q;
  assign saturated_o  = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ov_q    <= 1'b0;
    end else begin
      if (pop_i && ov_q) ov_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            s_q     <= q_data_i;
            state_q <= B_M1;
          end
        end
        B_M1: begin
          smag_q  <= dsp[32] ? 32'(-dsp) : dsp[31:0];
          sneg_q  <= dsp[32];
          m1_q    <= 49'(ma) * 49'(mb);
          dmag_q  <= div_i[32] ? 16'(-div_i) : div_i[15:0];
          omag_q  <= s_q.offs[45] ? 46'(-s_q.offs) : 46'(s_q.offs);
          cneg_q  <= div_i[32] ^ s_q.offs[45] ^ dsp[32];
          state_q <= B_M2;
        end
        B_M2: begin
          acc_q   <= $signed({sdiff, 16'd0});
          div_q   <= {62'(omag_q) * 62'(dmag_q), 16'd0};
          rem_q   <= '0;
          quo_q   <= '0;
          huge_q  <= 1'b0;
          j_q     <= 7'(DivSteps - 1);
          state_q <= (s_q.red == RED_SUM && s_q.bl == BL_LIN && smag_q != '0) ? B_DIV : B_FIN;
        end
        B_DIV: begin
          // one quotient bit per cycle, restoring
          rem_q <= qbit ? 33'(rem_sh - {2'b00, smag_q}) : rem_sh[32:0];
          quo_q <= {quo_q[62:0], qbit};
          if (qbit && j_q >= 7'd64) huge_q <= 1'b1;
          div_q <= {div_q[76:0], 1'b0};
          if (j_q == '0) state_q <= B_FIN;
          else j_q <= j_q - 7'd1;
        end
        B_FIN: begin
          if (!ov_q) begin
            val_q   <= fval;
            zs_q    <= fzs;
            sat_q   <= fsat;
            ov_q    <= 1'b1;
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_zs_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && zs_q) |-> (val_q == '0 && !sat_q)) else $error("zero span result not clean");
  a_div_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> smag_q != '0) else $error("divide by zero span");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == B_M1) else $error("snapshot not taken");

endmodule

/* rtl/core/spectral_band_reducer.sv */
`timescale 1ns / 1ps
// Input: taken only while the front is idle; in-band words are latched, multiplied and
// trapezoid-added, out-of-band, restart or overflow words skip the add, and a high-edge
// word adds a hand-off state that waits for queue room. Result: empty drops after the
// queue and back M1, M2 and FIN states (FIN waits for a free output); sum mode with
// linear baseline adds the bit-serial divider. A 2-entry queue lets the front run on.
// Reset (rst_ni, async, active low) clears config registers, accumulators and the queue at once.
module spectral_band_reducer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [11:0] channel_index_i,
  input  logic [15:0] intensity_i,
  input  logic [31:0] position_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] band_value_o,
  output logic        zero_span_o,
  output logic        saturated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import sbr_pkg::*;

  snap_t wr_data, rd_data;
  logic  q_push, q_full, q_pop, q_empty;

  sbr_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .ch_i(channel_index_i), .iv_i(intensity_i), .pv_i(position_i),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(wr_data)
  );

  sbr_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(wr_data), .full_o(q_full),
    .pop_i(q_pop), .data_o(rd_data), .empty_o(q_empty)
  );

  sbr_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_data_i(rd_data), .q_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop),
    .band_value_o, .zero_span_o, .saturated_o
  );

endmodule
